[hdl/raid6_stripe_address_mapper_core_assert.svh]
// assertion macros for the checker file
`ifndef RAID6_STRIPE_ADDRESS_MAPPER_CORE_ASSERT_SVH
`define RAID6_STRIPE_ADDRESS_MAPPER_CORE_ASSERT_SVH

// same-cycle implication
`define R6SAM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("r6sam check failed");

// next-cycle implication
`define R6SAM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("r6sam check failed");

`endif

[hdl/raid6sam_pkg.sv]
// shared widths, register codes and transaction types of the stripe mapper
package raid6sam_pkg;

  localparam int OFF_W     = 48;
  localparam int LEN_W     = 21;
  localparam int DRV_W     = 7;
  localparam int NDRV_W    = 5;
  localparam int DLY_W     = 16;
  localparam int KIB_W     = 11;
  localparam int KIB_SHIFT = 10;
  localparam int CFG_IDX_W = 3;
  localparam int QDEPTH    = 2;

  localparam int DEF_MAX_DRIVES   = 16;
  localparam int DEF_MAX_SEGMENTS = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_DRIVES    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PARITY_DELAY  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIPE_KIB    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ARRAY_BYTES   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PHYS_OFFSET   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MISSING_DRIVE = 3'd5;

  localparam logic [NDRV_W-1:0] RST_NUM_DRIVES    = 5'd4;
  localparam logic [DLY_W-1:0]  RST_PARITY_DELAY  = 16'd16;
  localparam logic [KIB_W-1:0]  RST_STRIPE_KIB    = 11'd256;
  localparam logic [NDRV_W-1:0] RST_MISSING_DRIVE = 5'd16;

  // effective configuration after clamping
  typedef struct packed {
    logic [DRV_W-1:0]  d;
    logic [DRV_W-1:0]  n;
    logic [DLY_W-1:0]  dly;
    logic [KIB_W-1:0]  kib;
    logic [OFF_W-1:0]  array_bytes;
    logic [OFF_W-1:0]  phys;
    logic [NDRV_W-1:0] missing;
  } cfg_t;

  // starting point of one request for the segment generator
  typedef struct packed {
    logic              oor;
    logic [OFF_W-1:0]  row;
    logic [DRV_W-1:0]  col;
    logic [LEN_W-1:0]  rel;
    logic [DLY_W-1:0]  phase;
    logic [DRV_W-1:0]  slot;
    logic [OFF_W-1:0]  base;
    logic [LEN_W-1:0]  rem;
    logic [OFF_W-1:0]  w;
    logic [LEN_W-1:0]  l;
  } job_t;

endpackage

[hdl/raid6sam_div.sv]
// restoring divider, one quotient bit per cycle
module raid6sam_div
  import raid6sam_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [OFF_W-1:0] dividend_i,
  input  logic [OFF_W-1:0] divisor_i,
  output logic             done_o,
  output logic [OFF_W-1:0] quot_o,
  output logic [OFF_W-1:0] rem_o
);

  localparam int CNT_W = $clog2(OFF_W);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [OFF_W-1:0] dvd_q;
  logic [OFF_W-1:0] rem_q;
  logic [OFF_W-1:0] dvs_q;
  logic [OFF_W:0]   trial;
  logic             take;

  assign trial = {rem_q, dvd_q[OFF_W-1]};
  assign take  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CNT_W'(OFF_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[OFF_W-2:0], take};
      rem_q <= take ? OFF_W'(trial - {1'b0, dvs_q}) : trial[OFF_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;
  assign rem_o  = rem_q;

endmodule

[hdl/raid6sam_queue.sv]
// short queue of request transactions between front and back
module raid6sam_queue
  import raid6sam_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output job_t data_o,
  output logic empty_o
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  job_t             mem_q [QDEPTH];
  logic [PTR_W-1:0] wr_q;
  logic [PTR_W-1:0] rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = cnt_q == CNT_W'(QDEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

[hdl/raid6sam_front.sv]
// request front end: range check and start position through the shared divider
module raid6sam_front
  import raid6sam_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [OFF_W-1:0] logical_offset_i,
  input  logic [LEN_W-1:0] request_length_i,
  output logic             push_o,
  output job_t             job_o,
  input  logic             full_i
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_W    = 4'd1;
  localparam logic [3:0] ST_L    = 4'd2;
  localparam logic [3:0] ST_K    = 4'd3;
  localparam logic [3:0] ST_SN   = 4'd4;
  localparam logic [3:0] ST_RC   = 4'd5;
  localparam logic [3:0] ST_PH   = 4'd6;
  localparam logic [3:0] ST_SL   = 4'd7;
  localparam logic [3:0] ST_MUL  = 4'd8;
  localparam logic [3:0] ST_BASE = 4'd9;
  localparam logic [3:0] ST_PUSH = 4'd10;

  localparam int PROD_W = OFF_W - KIB_SHIFT;

  logic [3:0]        state_q, state_d;
  logic [OFF_W-1:0]  off_q;
  logic [LEN_W-1:0]  len_q;
  logic [OFF_W-1:0]  w_q;
  logic [OFF_W-1:0]  r_q;
  logic [LEN_W-1:0]  l_q;
  logic              oor_q;
  logic [OFF_W-1:0]  row_q;
  logic [DRV_W-1:0]  col_q;
  logic [LEN_W-1:0]  rel_q;
  logic [DLY_W-1:0]  phase_q;
  logic [DRV_W-1:0]  slot_q;
  logic [OFF_W-1:0]  base_q;

  logic              div_start;
  logic [OFF_W-1:0]  div_a;
  logic [OFF_W-1:0]  div_b;
  logic              div_done;
  logic [OFF_W-1:0]  div_quot;
  logic [OFF_W-1:0]  div_rem;

  logic [KIB_W+DRV_W-1:0] kib_n;
  logic [OFF_W-1:0]  row_bytes;
  logic [OFF_W-1:0]  row_start;
  logic [OFF_W-1:0]  data_end;
  logic              is_oor;
  logic [PROD_W-1:0] prod;

  raid6sam_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_a),
    .divisor_i (div_b),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  assign kib_n     = cfg_i.kib * cfg_i.n;
  assign row_bytes = OFF_W'({kib_n, {KIB_SHIFT{1'b0}}});
  assign row_start = cfg_i.array_bytes - r_q;
  // last row holds n*l bytes, so the end is the size less r mod n
  assign data_end  = cfg_i.array_bytes - div_rem;
  assign is_oor    = (off_q >= cfg_i.array_bytes) || (off_q >= data_end);
  assign prod      = PROD_W'(row_q[PROD_W-1:0] * cfg_i.kib);

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    div_a     = '0;
    div_b     = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          div_start = 1'b1;
          div_a     = cfg_i.array_bytes;
          div_b     = row_bytes;
          state_d   = ST_W;
        end
      end
      ST_W: begin
        if (div_done) begin
          div_start = 1'b1;
          div_a     = div_rem;
          div_b     = OFF_W'(cfg_i.n);
          state_d   = ST_L;
        end
      end
      ST_L: begin
        if (div_done) begin
          if (is_oor) begin
            state_d = ST_PUSH;
          end else if (len_q == '0) begin
            state_d = ST_IDLE;
          end else if (off_q >= row_start) begin
            div_start = 1'b1;
            div_a     = off_q - row_start;
            div_b     = OFF_W'(div_quot[LEN_W-1:0]);
            state_d   = ST_K;
          end else begin
            div_start = 1'b1;
            div_a     = off_q >> KIB_SHIFT;
            div_b     = OFF_W'(cfg_i.kib);
            state_d   = ST_SN;
          end
        end
      end
      ST_K: begin
        if (div_done) begin
          div_start = 1'b1;
          div_a     = w_q;
          div_b     = OFF_W'(cfg_i.dly);
          state_d   = ST_PH;
        end
      end
      ST_SN: begin
        if (div_done) begin
          div_start = 1'b1;
          div_a     = div_quot;
          div_b     = OFF_W'(cfg_i.n);
          state_d   = ST_RC;
        end
      end
      ST_RC: begin
        if (div_done) begin
          div_start = 1'b1;
          div_a     = div_quot;
          div_b     = OFF_W'(cfg_i.dly);
          state_d   = ST_PH;
        end
      end
      ST_PH: begin
        if (div_done) begin
          div_start = 1'b1;
          div_a     = div_quot;
          div_b     = OFF_W'(cfg_i.d);
          state_d   = ST_SL;
        end
      end
      ST_SL: begin
        if (div_done) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_BASE;
      end
      ST_BASE: begin
        state_d = ST_PUSH;
      end
      ST_PUSH: begin
        if (!full_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        off_q <= logical_offset_i;
        len_q <= request_length_i;
        oor_q <= 1'b0;
      end
      ST_W: begin
        if (div_done) begin
          w_q <= div_quot;
          r_q <= div_rem;
        end
      end
      ST_L: begin
        if (div_done) begin
          l_q   <= div_quot[LEN_W-1:0];
          oor_q <= is_oor;
        end
      end
      ST_K: begin
        if (div_done) begin
          col_q <= div_quot[DRV_W-1:0];
          rel_q <= div_rem[LEN_W-1:0];
          row_q <= w_q;
        end
      end
      ST_SN: begin
        if (div_done) begin
          rel_q <= {div_rem[KIB_W-1:0], off_q[KIB_SHIFT-1:0]};
        end
      end
      ST_RC: begin
        if (div_done) begin
          row_q <= div_quot;
          col_q <= div_rem[DRV_W-1:0];
        end
      end
      ST_PH: begin
        if (div_done) begin
          phase_q <= div_rem[DLY_W-1:0];
        end
      end
      ST_SL: begin
        if (div_done) begin
          slot_q <= div_rem[DRV_W-1:0];
        end
      end
      ST_MUL: begin
        base_q <= {prod, {KIB_SHIFT{1'b0}}};
      end
      ST_BASE: begin
        base_q <= base_q + cfg_i.phys;
      end
      default: begin
      end
    endcase
  end

  assign in_stall_o = state_q != ST_IDLE;
  assign push_o     = (state_q == ST_PUSH) && !full_i;

  always_comb begin
    job_o       = '0;
    job_o.oor   = oor_q;
    job_o.row   = row_q;
    job_o.col   = col_q;
    job_o.rel   = rel_q;
    job_o.phase = phase_q;
    job_o.slot  = slot_q;
    job_o.base  = base_q;
    job_o.rem   = len_q;
    job_o.w     = w_q;
    job_o.l     = l_q;
  end

endmodule

[hdl/raid6sam_back.sv]
// segment generator: one result per unstalled cycle with incremental row and parity tracking
module raid6sam_back
  import raid6sam_pkg::*;
#(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  job_t             job_i,
  input  logic             empty_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [3:0]       drive_index_o,
  output logic [OFF_W-1:0] drive_offset_o,
  output logic [LEN_W-1:0] segment_length_o,
  output logic             needs_recovery_o,
  output logic             out_of_range_o,
  output logic             truncated_o,
  output logic             last_segment_o
);

  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

  logic             act_q;
  job_t             cur_q;
  logic [CNT_W-1:0] cnt_q;
  logic             out_valid_q;
  logic [3:0]       drv_q;
  logic [OFF_W-1:0] doff_q;
  logic [LEN_W-1:0] seg_q;
  logic             rec_q, oor_q, trunc_q, last_q;

  logic             emit;
  logic [LEN_W-1:0] stripe;
  logic [LEN_W-1:0] size;
  logic [LEN_W-1:0] seg_full;
  logic [LEN_W-1:0] seg;
  logic [LEN_W-1:0] rem_nxt;
  logic             last;
  logic [DRV_W-1:0] slot_nxt;
  logic [DRV_W-1:0] pd, qd, sd0, sd1, sd;

  assign stripe   = {cfg_i.kib, {KIB_SHIFT{1'b0}}};
  assign size     = (cur_q.row == cur_q.w && cur_q.l != '0) ? cur_q.l : stripe;
  assign seg_full = size - cur_q.rel;
  assign seg      = (seg_full > cur_q.rem) ? cur_q.rem : seg_full;
  assign rem_nxt  = cur_q.rem - seg;
  assign last     = (rem_nxt == '0) || (cnt_q == CNT_W'(MAX_SEGMENTS - 1));

  // q sits on drive d-1-slot, p on the drive for the slot one row-group ahead
  assign slot_nxt = (cur_q.slot == cfg_i.d - 1'b1) ? '0 : cur_q.slot + 1'b1;
  assign qd       = cfg_i.d - 1'b1 - cur_q.slot;
  assign pd       = cfg_i.d - 1'b1 - slot_nxt;
  assign sd0      = cur_q.col;
  assign sd1      = (sd0 >= pd) ? sd0 + 1'b1 : sd0;
  assign sd       = (sd1 >= qd) ? sd1 + 1'b1 : sd1;

  assign emit  = act_q && (!out_valid_q || !out_stall_i);
  assign pop_o = !act_q && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q       <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (pop_o) begin
        act_q <= 1'b1;
        cnt_q <= '0;
      end else if (emit) begin
        cnt_q <= cnt_q + 1'b1;
        if (cur_q.oor || last) begin
          act_q <= 1'b0;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= job_i;
    end else if (emit) begin
      cur_q.rem <= rem_nxt;
      cur_q.rel <= '0;
      if (cur_q.col == cfg_i.n - 1'b1) begin
        cur_q.col  <= '0;
        cur_q.row  <= cur_q.row + 1'b1;
        cur_q.base <= cur_q.base + OFF_W'(stripe);
        if (cur_q.phase == cfg_i.dly - 1'b1) begin
          cur_q.phase <= '0;
          cur_q.slot  <= slot_nxt;
        end else begin
          cur_q.phase <= cur_q.phase + 1'b1;
        end
      end else begin
        cur_q.col <= cur_q.col + 1'b1;
      end
    end
    if (emit) begin
      if (cur_q.oor) begin
        drv_q   <= '0;
        doff_q  <= '0;
        seg_q   <= '0;
        rec_q   <= 1'b0;
        oor_q   <= 1'b1;
        trunc_q <= 1'b0;
        last_q  <= 1'b1;
      end else begin
        drv_q   <= sd[3:0];
        doff_q  <= cur_q.base + OFF_W'(cur_q.rel);
        seg_q   <= seg;
        rec_q   <= sd == DRV_W'(cfg_i.missing);
        oor_q   <= 1'b0;
        trunc_q <= last && (rem_nxt != '0);
        last_q  <= last;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign drive_index_o    = drv_q;
  assign drive_offset_o   = doff_q;
  assign segment_length_o = seg_q;
  assign needs_recovery_o = rec_q;
  assign out_of_range_o   = oor_q;
  assign truncated_o      = trunc_q;
  assign last_segment_o   = last_q;

endmodule

[hdl/raid6_stripe_address_mapper_core.sv]
// raid6 stripe address mapper top level: config registers, front end, queue, back end
//
//   channel  direction  handshake            payload
//   in       input      in_valid_i/in_stall_o    logical_offset_i, request_length_i
//   out      output     out_valid_o/out_stall_i  drive_index_o .. last_segment_o
//   cfg      input      cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// the front end uses the shared one-bit-per-cycle divider in passes: an empty
// request takes 2 passes, a rejected one 2 passes and a push, others 5 or 6 passes
// plus multiply, add and push before the next is taken.
// the back end emits one segment per unstalled cycle, up to MAX_SEGMENTS per request.
// reset clears control state only; there is no clearing pass.
// a two-deep queue lets the front end take the next request while segments drain.
module raid6_stripe_address_mapper_core
  import raid6sam_pkg::*;
#(
  parameter int MAX_DRIVES   = DEF_MAX_DRIVES,
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [OFF_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [OFF_W-1:0]     logical_offset_i,
  input  logic [LEN_W-1:0]     request_length_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [3:0]           drive_index_o,
  output logic [OFF_W-1:0]     drive_offset_o,
  output logic [LEN_W-1:0]     segment_length_o,
  output logic                 needs_recovery_o,
  output logic                 out_of_range_o,
  output logic                 truncated_o,
  output logic                 last_segment_o
);

  logic [NDRV_W-1:0] num_drives_q;
  logic [DLY_W-1:0]  parity_delay_q;
  logic [KIB_W-1:0]  stripe_kib_q;
  logic [OFF_W-1:0]  array_bytes_q;
  logic [OFF_W-1:0]  phys_offset_q;
  logic [NDRV_W-1:0] missing_drive_q;

  cfg_t              cfg;
  logic [DRV_W-1:0]  nd;
  logic              push, full, pop, empty;
  job_t              job_in, job_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_drives_q    <= RST_NUM_DRIVES;
      parity_delay_q  <= RST_PARITY_DELAY;
      stripe_kib_q    <= RST_STRIPE_KIB;
      array_bytes_q   <= '0;
      phys_offset_q   <= '0;
      missing_drive_q <= RST_MISSING_DRIVE;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_NUM_DRIVES:    num_drives_q    <= cfg_data_i[NDRV_W-1:0];
        CFG_PARITY_DELAY:  parity_delay_q  <= cfg_data_i[DLY_W-1:0];
        CFG_STRIPE_KIB:    stripe_kib_q    <= cfg_data_i[KIB_W-1:0];
        CFG_ARRAY_BYTES:   array_bytes_q   <= cfg_data_i;
        CFG_PHYS_OFFSET:   phys_offset_q   <= cfg_data_i;
        CFG_MISSING_DRIVE: missing_drive_q <= cfg_data_i[NDRV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // clamp drive count, parity delay and stripe size into their working range
  assign nd = DRV_W'(num_drives_q);

  always_comb begin
    cfg = '0;
    if (nd < DRV_W'(4)) begin
      cfg.d = DRV_W'(4);
    end else if (nd > DRV_W'(MAX_DRIVES)) begin
      cfg.d = DRV_W'(MAX_DRIVES);
    end else begin
      cfg.d = nd;
    end
    cfg.n           = cfg.d - DRV_W'(2);
    cfg.dly         = (parity_delay_q == '0) ? DLY_W'(1) : parity_delay_q;
    cfg.kib         = (stripe_kib_q == '0) ? KIB_W'(1) : stripe_kib_q;
    cfg.array_bytes = array_bytes_q;
    cfg.phys        = phys_offset_q;
    cfg.missing     = missing_drive_q;
  end

  raid6sam_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .logical_offset_i(logical_offset_i),
    .request_length_i(request_length_i),
    .push_o          (push),
    .job_o           (job_in),
    .full_i          (full)
  );

  raid6sam_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (job_in),
    .full_o (full),
    .pop_i  (pop),
    .data_o (job_out),
    .empty_o(empty)
  );

  raid6sam_back #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .job_i           (job_out),
    .empty_i         (empty),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .drive_index_o   (drive_index_o),
    .drive_offset_o  (drive_offset_o),
    .segment_length_o(segment_length_o),
    .needs_recovery_o(needs_recovery_o),
    .out_of_range_o  (out_of_range_o),
    .truncated_o     (truncated_o),
    .last_segment_o  (last_segment_o)
  );

endmodule

[hdl/raid6sam_chk.sv]
// port-level checks of the stripe mapper, bound to the top level
`include "raid6_stripe_address_mapper_core_assert.svh"

module raid6sam_chk
  import raid6sam_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 cfg_valid_i,
  input logic                 cfg_ready_o,
  input logic [CFG_IDX_W-1:0] cfg_index_i,
  input logic [OFF_W-1:0]     cfg_data_i,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic [OFF_W-1:0]     logical_offset_i,
  input logic [LEN_W-1:0]     request_length_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [3:0]           drive_index_o,
  input logic [OFF_W-1:0]     drive_offset_o,
  input logic [LEN_W-1:0]     segment_length_o,
  input logic                 needs_recovery_o,
  input logic                 out_of_range_o,
  input logic                 truncated_o,
  input logic                 last_segment_o
);

  // rejected request gives one cleared, final result
  `R6SAM_ASSERT_IMP(a_oor_shape, clk_i, rst_ni, out_valid_o && out_of_range_o,
                    last_segment_o && segment_length_o == '0 && !needs_recovery_o &&
                    !truncated_o)

  `R6SAM_ASSERT_IMP(a_trunc_last, clk_i, rst_ni, out_valid_o && truncated_o, last_segment_o)

  // every real segment carries at least one byte
  `R6SAM_ASSERT_IMP(a_seg_nonzero, clk_i, rst_ni, out_valid_o && !out_of_range_o,
                    segment_length_o != '0)

  `R6SAM_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                    out_valid_o && $stable(drive_offset_o) && $stable(segment_length_o))

endmodule

bind raid6_stripe_address_mapper_core raid6sam_chk u_chk (.*);
